// ----- rtl/core/sfr_pkg.sv -----
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W     = 4;
  localparam int MAX_BYTES = CFG_W / BYTE_W;

  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;
  localparam int CMDQ_DEPTH          = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN            = 2'd0,
    REG_PATTERN_LENGTH     = 2'd1,
    REG_REPLACEMENT        = 2'd2,
    REG_REPLACEMENT_LENGTH = 2'd3
  } cfg_reg_t;

  // usable length: the register words carry at most MAX_BYTES bytes
  function automatic int cap_bytes(input int v);
    return (v < MAX_BYTES) ? v : MAX_BYTES;
  endfunction

  // widest run of result bytes one request can cause
  function automatic int emit_depth(input int max_pattern, input int max_replacement);
    int p;
    int r;
    p = cap_bytes(max_pattern);
    r = cap_bytes(max_replacement);
    return (p > r) ? p : r;
  endfunction

endpackage

// ----- rtl/core/sfr_front.sv -----
`timescale 1ns / 1ps

module sfr_front #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT,
  localparam int P     = sfr_pkg::cap_bytes(MAX_PATTERN),
  localparam int R     = sfr_pkg::cap_bytes(MAX_REPLACEMENT),
  localparam int EMIT  = sfr_pkg::emit_depth(MAX_PATTERN, MAX_REPLACEMENT),
  localparam int CNT_W = $clog2(EMIT + 1)
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]                 cfg_data,
  input  logic                                      push,
  input  logic [sfr_pkg::BYTE_W-1:0]                char_in,
  input  logic                                      end_of_text,
  input  logic                                      q_full,
  output logic                                      enq,
  output logic [EMIT-1:0][sfr_pkg::BYTE_W-1:0]      cmd_bytes,
  output logic [CNT_W-1:0]                          cmd_count,
  output logic                                      cmd_eot
);

  localparam int PC_W  = $clog2(P + 1);
  localparam int SUM_W = PC_W + 1;
  localparam int BW    = sfr_pkg::BYTE_W;

  logic [sfr_pkg::CFG_W-1:0] pattern;
  logic [sfr_pkg::LEN_W-1:0] pattern_length;
  logic [sfr_pkg::CFG_W-1:0] replacement;
  logic [sfr_pkg::LEN_W-1:0] replacement_length;

  logic [P-1:0][BW-1:0] held;
  logic [P-1:0][BW-1:0] held_next;
  logic [PC_W-1:0]      held_count;

  logic [P-1:0][BW-1:0] win;
  logic [PC_W-1:0]      n;
  logic [PC_W-1:0]      plen;
  logic [CNT_W-1:0]     rlen;
  logic [PC_W-1:0]      s_sel;
  logic [P-1:0]         ok;
  logic                 hit;
  logic                 accept;
  logic                 pat_wr;

  assign accept = push && !q_full;
  assign enq    = accept && (cmd_count != '0);
  assign pat_wr = cfg_we &&
                  (cfg_index inside {sfr_pkg::REG_PATTERN, sfr_pkg::REG_PATTERN_LENGTH});

  always_comb begin
    n = held_count + 1'b1;
    for (int i = 0; i < P; i++) begin
      win[i] = (PC_W'(i) < held_count) ? held[i] : char_in;
    end

    // zero length acts as one, long lengths are clipped
    if (pattern_length == '0) begin
      plen = PC_W'(1);
    end else if (pattern_length > sfr_pkg::LEN_W'(P)) begin
      plen = PC_W'(P);
    end else begin
      plen = PC_W'(pattern_length);
    end
    if (replacement_length > sfr_pkg::LEN_W'(R)) begin
      rlen = CNT_W'(R);
    end else begin
      rlen = CNT_W'(replacement_length);
    end

    hit = (n == plen);
    for (int i = 0; i < P; i++) begin
      if ((PC_W'(i) < n) && (win[i] != pattern[BW*i +: BW])) begin
        hit = 1'b0;
      end
    end

    // tail starting at s must be a proper prefix of the pattern
    for (int s = 0; s < P; s++) begin
      ok[s] = (PC_W'(s) < n) && ((n - PC_W'(s)) < plen);
      for (int i = s; i < P; i++) begin
        if ((PC_W'(i) < n) && (win[i] != pattern[BW*(i-s) +: BW])) begin
          ok[s] = 1'b0;
        end
      end
    end
    s_sel = n;
    for (int s = P - 1; s >= 0; s--) begin
      if (ok[s]) begin
        s_sel = PC_W'(s);
      end
    end

    cmd_bytes = '0;
    if (hit) begin
      for (int i = 0; i < R; i++) begin
        cmd_bytes[i] = replacement[BW*i +: BW];
      end
    end else begin
      for (int i = 0; i < P; i++) begin
        cmd_bytes[i] = win[i];
      end
    end
    if (hit) begin
      cmd_count = rlen;
    end else if (end_of_text) begin
      cmd_count = CNT_W'(n);
    end else begin
      cmd_count = CNT_W'(s_sel);
    end
    cmd_eot = end_of_text;

    // kept bytes slide down to the front of the hold buffer
    for (int i = 0; i < P; i++) begin
      held_next[i] = held[i];
      for (int j = 0; j < P; j++) begin
        if (SUM_W'(j) == (SUM_W'(s_sel) + SUM_W'(i))) begin
          held_next[i] = win[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern            <= '0;
      pattern_length     <= sfr_pkg::LEN_W'(1);
      replacement        <= '0;
      replacement_length <= '0;
      held_count         <= '0;
    end else begin
      // a pattern or pattern length write drops the held bytes
      if (pat_wr) begin
        held_count <= '0;
      end else if (accept) begin
        held_count <= (hit || end_of_text) ? '0 : (n - s_sel);
      end
      if (cfg_we) begin
        unique case (sfr_pkg::cfg_reg_t'(cfg_index))
          sfr_pkg::REG_PATTERN: begin
            pattern <= cfg_data;
          end
          sfr_pkg::REG_PATTERN_LENGTH: begin
            pattern_length <= cfg_data[sfr_pkg::LEN_W-1:0];
          end
          sfr_pkg::REG_REPLACEMENT: begin
            replacement <= cfg_data;
          end
          sfr_pkg::REG_REPLACEMENT_LENGTH: begin
            replacement_length <= cfg_data[sfr_pkg::LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= held_next;
    end
  end

`ifndef SYNTHESIS
  a_held_short: assert property (@(posedge clk) disable iff (rst)
    held_count < plen)
    else $error("hold buffer reached the pattern length");

  a_eot_flush: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_text |=> held_count == '0)
    else $error("bytes still held after end of text");

  a_enq_room: assert property (@(posedge clk) disable iff (rst)
    enq |-> !q_full && push)
    else $error("command written into a full queue");
`endif

endmodule

// ----- rtl/core/sfr_cmdq.sv -----
`timescale 1ns / 1ps

module sfr_cmdq #(
  parameter int W     = 1,
  parameter int DEPTH = sfr_pkg::CMDQ_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/sfr_back.sv -----
`timescale 1ns / 1ps

module sfr_back #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT,
  localparam int EMIT  = sfr_pkg::emit_depth(MAX_PATTERN, MAX_REPLACEMENT),
  localparam int CNT_W = $clog2(EMIT + 1)
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  logic [EMIT-1:0][sfr_pkg::BYTE_W-1:0] q_bytes,
  input  logic [CNT_W-1:0]                     q_count,
  input  logic                                 q_eot,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [sfr_pkg::BYTE_W-1:0]           char_out,
  output logic                                 last_of_run,
  output logic                                 text_done
);

  localparam int IDX_W = (EMIT > 1) ? $clog2(EMIT) : 1;

  logic                                 busy;
  logic [EMIT-1:0][sfr_pkg::BYTE_W-1:0] cur_bytes;
  logic [CNT_W-1:0]                     cur_count;
  logic                                 cur_eot;
  logic [IDX_W-1:0]                     cur_idx;
  logic                                 out_valid;
  logic                                 slot_free;
  logic                                 cur_last;
  logic                                 emit;
  logic                                 load;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign cur_last  = busy && ((CNT_W'(cur_idx) + 1'b1) == cur_count);
  assign emit      = busy && slot_free;
  // next command loads when idle, or as the current one hands over its final byte
  assign load      = !q_empty && (!busy || (emit && cur_last));
  assign q_pop     = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cur_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        busy    <= 1'b1;
        cur_idx <= '0;
      end else if (emit && cur_last) begin
        busy <= 1'b0;
      end else if (emit) begin
        cur_idx <= cur_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_bytes <= q_bytes;
      cur_count <= q_count;
      cur_eot   <= q_eot;
    end
    if (emit) begin
      char_out    <= cur_bytes[cur_idx];
      last_of_run <= cur_last;
      text_done   <= cur_last && cur_eot;
    end
  end

endmodule

// ----- rtl/core/stream_find_and_replace.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// ------------------------------------------------------------------------
// input     in         push / full          char_in, end_of_text
// result    out        empty / pop          char_out, last_of_run, text_done
// config    in         cfg_we (no stall)    cfg_index, cfg_data
//
// the front takes one byte a cycle while the command queue has room; the
// match search over the held bytes finishes in that same cycle
// the back hands out one result byte a cycle unless pop low holds it; an
// input yields 1 to 8 result bytes or none, and one with none never reaches the back
// rst is synchronous: clears held bytes, queue and output, loads register defaults
// pop low holds the result register; full rises when the two-entry queue fills

module stream_find_and_replace #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          push,
  output logic                          full,
  input  logic [sfr_pkg::BYTE_W-1:0]    char_in,
  input  logic                          end_of_text,
  output logic                          empty,
  input  logic                          pop,
  output logic [sfr_pkg::BYTE_W-1:0]    char_out,
  output logic                          last_of_run,
  output logic                          text_done
);

  localparam int EMIT   = sfr_pkg::emit_depth(MAX_PATTERN, MAX_REPLACEMENT);
  localparam int CNT_W  = $clog2(EMIT + 1);
  localparam int BYTES_W = EMIT * sfr_pkg::BYTE_W;
  localparam int QW     = BYTES_W + CNT_W + 1;

  logic                                 enq;
  logic [EMIT-1:0][sfr_pkg::BYTE_W-1:0] cmd_bytes;
  logic [CNT_W-1:0]                     cmd_count;
  logic                                 cmd_eot;
  logic                                 q_full;
  logic                                 q_empty;
  logic                                 q_pop;
  logic [QW-1:0]                        q_wr_data;
  logic [QW-1:0]                        q_rd_data;
  logic [EMIT-1:0][sfr_pkg::BYTE_W-1:0] q_bytes;

  assign full      = q_full;
  assign q_wr_data = {cmd_eot, cmd_count, cmd_bytes};
  assign q_bytes   = q_rd_data[BYTES_W-1:0];

  sfr_front #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_REPLACEMENT(MAX_REPLACEMENT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .char_in    (char_in),
    .end_of_text(end_of_text),
    .q_full     (q_full),
    .enq        (enq),
    .cmd_bytes  (cmd_bytes),
    .cmd_count  (cmd_count),
    .cmd_eot    (cmd_eot)
  );

  sfr_cmdq #(
    .W    (QW),
    .DEPTH(sfr_pkg::CMDQ_DEPTH)
  ) u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (enq),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  sfr_back #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_REPLACEMENT(MAX_REPLACEMENT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_bytes    (q_bytes),
    .q_count    (q_rd_data[BYTES_W +: CNT_W]),
    .q_eot      (q_rd_data[QW-1]),
    .empty      (empty),
    .pop        (pop),
    .char_out   (char_out),
    .last_of_run(last_of_run),
    .text_done  (text_done)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int RAND_ITEMS  = 500;
  localparam int CALM_FROM   = 420;
  localparam int SETTLE      = 12;
  localparam int WATCHDOG    = 2000;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_ONE} chk_t;

  typedef struct packed {
    row_kind_t           kind;
    cfg_reg_t            idx;
    logic [CFG_W-1:0]    data;
    logic [BYTE_W-1:0]   ch;
    logic                eot;
    chk_t                chk;
    logic [BYTE_W-1:0]   want;
  } stim_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
    logic              done;
  } out_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 push = 1'b0;
  logic                 full;
  logic [BYTE_W-1:0]    char_in = '0;
  logic                 end_of_text = 1'b0;
  logic                 empty;
  logic                 pop = 1'b0;
  logic [BYTE_W-1:0]    char_out;
  logic                 last_of_run;
  logic                 text_done;

  // directed-row tags travel with the request
  chk_t                 typed_chk = CHK_PREDICT;
  logic [BYTE_W-1:0]    typed_ch = '0;

  // shadow of the block: registers and held prefix
  logic [CFG_W-1:0]     pat_word = '0;
  logic [LEN_W-1:0]     pat_len_reg = 4'd1;
  logic [CFG_W-1:0]     rep_word = '0;
  logic [LEN_W-1:0]     rep_len_reg = 4'd0;
  logic [BYTE_W-1:0]    held_q [8];
  int                   held_n = 0;

  out_byte_t            pending_out [$];
  stim_row_t            stim_table [$];
  logic [BYTE_W-1:0]    text_q [$];
  int                   errors = 0;
  int                   stall_cycles = 0;
  bit                   calm = 1'b0;

  stream_find_and_replace u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .push        (push),
    .full        (full),
    .char_in     (char_in),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop),
    .char_out    (char_out),
    .last_of_run (last_of_run),
    .text_done   (text_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [BYTE_W-1:0] byte_at(input logic [CFG_W-1:0] w, input int i);
    return w[8*i +: 8];
  endfunction

  function automatic int eff_plen();
    int v;
    v = int'(pat_len_reg);
    if (v == 0) v = 1;
    if (v > 8) v = 8;
    return v;
  endfunction

  function automatic int eff_rlen();
    int v;
    v = int'(rep_len_reg);
    if (v > 8) v = 8;
    return v;
  endfunction

  // one input byte through the shadow; keep=0 only updates the held prefix
  task automatic predict_replace(input logic [BYTE_W-1:0] c, input logic eot, input bit keep);
    logic [BYTE_W-1:0] win [8];
    out_byte_t         run [8];
    int                plen, rlen, n, s, i, j, k;
    bit                hit, ok;
    plen = eff_plen();
    n = held_n;
    if (n > plen - 1) n = plen - 1;
    for (i = 0; i < n; i++) win[i] = held_q[i];
    win[n] = c;
    n++;
    k = 0;
    hit = (n == plen);
    for (i = 0; i < n; i++) if (win[i] != byte_at(pat_word, i)) hit = 1'b0;
    if (hit) begin
      rlen = eff_rlen();
      for (i = 0; i < rlen; i++) begin
        run[k] = out_byte_t'{byte_at(rep_word, i), 1'b0, 1'b0};
        k++;
      end
      held_n = 0;
    end else begin
      // earliest shift that leaves a proper prefix of the pattern
      s = n;
      for (j = 0; j < n; j++) begin
        ok = (n - j) < plen;
        for (i = j; i < n; i++) if (win[i] != byte_at(pat_word, i - j)) ok = 1'b0;
        if (ok && s == n) s = j;
      end
      for (i = 0; i < s; i++) begin
        run[k] = out_byte_t'{win[i], 1'b0, 1'b0};
        k++;
      end
      held_n = 0;
      for (i = s; i < n; i++) begin
        if (eot) begin
          run[k] = out_byte_t'{win[i], 1'b0, 1'b0};
          k++;
        end else begin
          held_q[held_n] = win[i];
          held_n++;
        end
      end
    end
    if (eot) held_n = 0;
    if (k > 0) begin
      run[k-1].last = 1'b1;
      run[k-1].done = eot;
    end
    if (keep) for (i = 0; i < k; i++) pending_out.push_back(run[i]);
  endtask

  function automatic void flag_mismatch(input string field, input logic [BYTE_W-1:0] want,
                                        input logic [BYTE_W-1:0] got);
    errors++;
    $error("%s: expected %0h, got %0h", field, want, got);
  endfunction

  always @(posedge clk) begin
    out_byte_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_out.size() == 0) begin
          flag_mismatch("char_out (no result expected)", 8'h00, char_out);
        end else begin
          e = pending_out.pop_front();
          if (char_out !== e.ch) flag_mismatch("char_out", e.ch, char_out);
          if (last_of_run !== e.last)
            flag_mismatch("last_of_run", BYTE_W'(e.last), BYTE_W'(last_of_run));
          if (text_done !== e.done)
            flag_mismatch("text_done", BYTE_W'(e.done), BYTE_W'(text_done));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PATTERN: begin
            pat_word = cfg_data;
            held_n = 0;
          end
          REG_PATTERN_LENGTH: begin
            pat_len_reg = cfg_data[LEN_W-1:0];
            held_n = 0;
          end
          REG_REPLACEMENT:        rep_word = cfg_data;
          REG_REPLACEMENT_LENGTH: rep_len_reg = cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        predict_replace(char_in, end_of_text, typed_chk == CHK_PREDICT);
        if (typed_chk == CHK_ONE)
          pending_out.push_back(out_byte_t'{typed_ch, 1'b1, end_of_text});
      end
    end
  end

  // no request moving on any port for too long
  always @(posedge clk) begin
    if (rst || cfg_we || (push && !full) || (pop && !empty)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] c, input logic eot, input chk_t chk,
                           input logic [BYTE_W-1:0] want);
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    push        <= 1'b1;
    char_in     <= c;
    end_of_text <= eot;
    typed_chk   <= chk;
    typed_ch    <= want;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  // registers change only once the block has gone quiet
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    push <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic void add_cfg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    stim_table.push_back(stim_row_t'{ROW_CFG, idx, data, 8'h00, 1'b0, CHK_NONE, 8'h00});
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] c, input logic eot, input chk_t chk,
                                   input logic [BYTE_W-1:0] want);
    stim_table.push_back(stim_row_t'{ROW_BYTE, REG_PATTERN, 64'd0, c, eot, chk, want});
  endfunction

  function automatic logic [CFG_W-1:0] len_word(input int v);
    logic [CFG_W-1:0] w;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 1) == 0) w = '0;
    w[LEN_W-1:0] = LEN_W'(v);
    return w;
  endfunction

  task automatic configure_phase(input bit all_regs);
    logic [CFG_W-1:0] pw, rw;
    logic [BYTE_W-1:0] a, b;
    int mode, i, j, r, plv, rlv;
    mode = $urandom_range(0, 2);
    a = BYTE_W'($urandom_range(0, 255));
    b = (mode == 2) ? a : BYTE_W'($urandom_range(0, 255));
    pw = {$urandom, $urandom};
    rw = {$urandom, $urandom};
    // few distinct letters give overlapping partial matches
    if (mode != 0) for (i = 0; i < 8; i++) pw[8*i +: 8] = $urandom_range(0, 1) ? a : b;
    if ($urandom_range(0, 2) == 0) begin
      for (i = 0; i < 8; i++) begin
        j = $urandom_range(0, 7);
        rw[8*i +: 8] = pw[8*j +: 8];
      end
    end
    r = $urandom_range(0, 9);
    plv = (r == 0) ? $urandom_range(0, 15) : (r <= 2) ? 8 : $urandom_range(1, 5);
    r = $urandom_range(0, 9);
    rlv = (r == 0) ? $urandom_range(0, 15) : $urandom_range(0, 8);
    if (all_regs || $urandom_range(0, 3) != 0) write_reg(REG_PATTERN, pw);
    if (all_regs || $urandom_range(0, 3) != 0) write_reg(REG_PATTERN_LENGTH, len_word(plv));
    if (all_regs || $urandom_range(0, 3) != 0) write_reg(REG_REPLACEMENT, rw);
    if (all_regs || $urandom_range(0, 3) != 0) write_reg(REG_REPLACEMENT_LENGTH, len_word(rlv));
  endtask

  task automatic make_text();
    int target, plen, rlen, i, len, bad;
    text_q.delete();
    plen = eff_plen();
    rlen = eff_rlen();
    target = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
    while (text_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: for (i = 0; i < plen; i++) text_q.push_back(byte_at(pat_word, i));
        3, 4: begin
          len = $urandom_range(1, plen);
          for (i = 0; i < len; i++) text_q.push_back(byte_at(pat_word, i));
        end
        5, 6: begin
          len = $urandom_range(1, 3);
          for (i = 0; i < len; i++)
            text_q.push_back(byte_at(pat_word, $urandom_range(0, plen - 1)));
        end
        7: text_q.push_back(BYTE_W'($urandom_range(0, 255)));
        8: begin
          bad = $urandom_range(0, plen - 1);
          for (i = 0; i < plen; i++)
            text_q.push_back((i == bad) ? BYTE_W'($urandom_range(0, 255))
                                        : byte_at(pat_word, i));
        end
        default: begin
          // replacement text in the input, and it must not be searched after emission
          for (i = 0; i < rlen; i++) text_q.push_back(byte_at(rep_word, i));
          if (rlen == 0) text_q.push_back(BYTE_W'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin
    int rand_items, phase_end, i;
    bit first;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset state: pattern 00 of length 1, deleting replacement
    add_byte(8'h41, 1'b0, CHK_ONE, 8'h41);
    add_byte(8'h00, 1'b0, CHK_NONE, 8'h00);
    add_byte(8'hFF, 1'b1, CHK_ONE, 8'hFF);
    add_cfg(REG_PATTERN, 64'h0000_0000_0063_6261);
    add_cfg(REG_PATTERN_LENGTH, 64'd3);
    add_cfg(REG_REPLACEMENT, 64'h0000_0000_0000_5958);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd2);
    add_byte(8'h61, 1'b0, CHK_NONE, 8'h00);
    add_byte(8'h62, 1'b0, CHK_NONE, 8'h00);
    add_byte(8'h63, 1'b0, CHK_PREDICT, 8'h00);
    add_byte(8'h61, 1'b0, CHK_NONE, 8'h00);
    add_byte(8'h61, 1'b0, CHK_PREDICT, 8'h00);
    add_byte(8'h62, 1'b0, CHK_NONE, 8'h00);
    add_byte(8'h78, 1'b1, CHK_PREDICT, 8'h00);
    // zero length acts as one, over-long replacement acts as eight
    add_cfg(REG_PATTERN, 64'h0123_4567_89AB_CDFF);
    add_cfg(REG_PATTERN_LENGTH, 64'd0);
    add_cfg(REG_REPLACEMENT, 64'hFF00_C3A5_5A3C_0081);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd15);
    add_byte(8'hFF, 1'b0, CHK_PREDICT, 8'h00);
    add_byte(8'h7F, 1'b1, CHK_ONE, 8'h7F);
    // eight-byte pattern deleted on the final byte: no result carries text_done
    add_cfg(REG_PATTERN, 64'h6161_6161_6161_6161);
    add_cfg(REG_PATTERN_LENGTH, 64'd15);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd0);
    for (i = 0; i < 8; i++) add_byte(8'h61, i == 7, CHK_NONE, 8'h00);
    // replacement write keeps the held prefix, pattern length write drops it
    add_cfg(REG_PATTERN, 64'h0000_0000_0000_6261);
    add_cfg(REG_PATTERN_LENGTH, 64'd2);
    add_cfg(REG_REPLACEMENT_LENGTH, 64'd8);
    add_byte(8'h61, 1'b0, CHK_NONE, 8'h00);
    add_cfg(REG_REPLACEMENT, 64'h8877_6655_4433_2211);
    add_byte(8'h62, 1'b0, CHK_PREDICT, 8'h00);
    add_byte(8'h61, 1'b0, CHK_NONE, 8'h00);
    add_cfg(REG_PATTERN_LENGTH, 64'd2);
    add_byte(8'h62, 1'b1, CHK_ONE, 8'h62);

    foreach (stim_table[r]) begin
      if (stim_table[r].kind == ROW_CFG) write_reg(stim_table[r].idx, stim_table[r].data);
      else send_byte(stim_table[r].ch, stim_table[r].eot, stim_table[r].chk, stim_table[r].want);
    end

    rand_items = 0;
    first = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      configure_phase(first);
      first = 1'b0;
      phase_end = rand_items + $urandom_range(20, 70);
      while (rand_items < phase_end && rand_items < RAND_ITEMS) begin
        make_text();
        foreach (text_q[t]) begin
          calm = (rand_items >= CALM_FROM);
          send_byte(text_q[t], t == text_q.size() - 1, CHK_PREDICT, 8'h00);
          rand_items++;
        end
      end
      // leave a partial match held across the next register writes
      if ($urandom_range(0, 2) == 0) begin
        for (i = 0; i < eff_plen() - 1; i++) begin
          send_byte(byte_at(pat_word, i), 1'b0, CHK_PREDICT, 8'h00);
          rand_items++;
        end
      end
    end

    calm = 1'b1;
    push <= 1'b0;
    while (pending_out.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sfr_pkg.sv
rtl/core/sfr_front.sv
rtl/core/sfr_cmdq.sv
rtl/core/sfr_back.sv
rtl/core/stream_find_and_replace.sv
tb/testbench.sv
